[sv/fwc_pkg.sv]
`default_nettype none
package fwc_pkg;

  localparam int BUF_BYTES = 128;
  localparam int BUF_WORDS = BUF_BYTES / 4;
  localparam int WIDX_W    = (BUF_WORDS > 1) ? $clog2(BUF_WORDS) : 1;
  localparam int CNT_W     = $clog2(BUF_BYTES + 1);
  localparam int ADDR_W    = 24;

  localparam logic [7:0] PAD_BYTE = 8'hff;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] byte_address;
    logic [7:0]        data_byte;
  } fwc_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] word_address;
    logic [31:0]       word_data;
    logic              last_word;
  } fwc_out_t;

  // controller -> datapath
  typedef struct packed {
    logic              take;
    logic              rd_en;
    logic              finish;
    logic [WIDX_W-1:0] word_idx;
  } fwc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_flush;
    logic last;
  } fwc_stat_t;

endpackage
`default_nettype wire

[sv/fwc_datapath.sv]
`default_nettype none
module fwc_datapath (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire fwc_pkg::fwc_in_t  in_data,
  input  wire fwc_pkg::fwc_cmd_t cmd,
  output fwc_pkg::fwc_stat_t     stat,
  output fwc_pkg::fwc_out_t      out_data
);

  logic [31:0] mem [fwc_pkg::BUF_WORDS];

  logic [fwc_pkg::CNT_W-1:0]  held_r;
  logic [fwc_pkg::CNT_W-1:0]  held_nxt;
  logic [fwc_pkg::ADDR_W-1:0] run_start_r;
  logic [fwc_pkg::ADDR_W-1:0] run_start_nxt;

  logic [fwc_pkg::ADDR_W-1:0] pend_addr_r;
  logic [7:0]                 pend_data_r;
  logic                       pend_write_r;

  logic [31:0]                rd_data_r;
  logic [fwc_pkg::ADDR_W-1:0] out_addr_r;

  logic                       is_write;
  logic                       held_zero;
  logic [fwc_pkg::ADDR_W-1:0] next_addr;
  logic                       brk;
  logic                       fills;
  logic [fwc_pkg::CNT_W-1:0]  held_m1;
  logic [fwc_pkg::WIDX_W-1:0] last_idx;
  logic [fwc_pkg::WIDX_W-1:0] wr_widx;
  logic [1:0]                 wr_lane;
  logic [31:0]                word_pad;

  assign is_write  = (in_data.op == fwc_pkg::OP_WRITE);
  assign held_zero = (held_r == '0);
  assign next_addr = run_start_r + fwc_pkg::ADDR_W'(held_r);
  assign brk       = !held_zero && (in_data.byte_address != next_addr);
  assign fills     = (held_r == fwc_pkg::CNT_W'(fwc_pkg::BUF_BYTES - 1));
  assign wr_widx   = held_r[fwc_pkg::WIDX_W+1:2];
  assign wr_lane   = held_r[1:0];

  // index of the final word held, valid while held_r is nonzero
  assign held_m1   = held_r - fwc_pkg::CNT_W'(1);
  assign last_idx  = held_m1[fwc_pkg::WIDX_W+1:2];

  assign stat.need_flush = (is_write && (brk || fills)) ||
                           ((in_data.op == fwc_pkg::OP_FLUSH) && !held_zero);
  assign stat.last       = (cmd.word_idx == last_idx);

  always_comb begin
    held_nxt      = held_r;
    run_start_nxt = run_start_r;
    if (cmd.take) begin
      case (in_data.op)
        fwc_pkg::OP_WRITE: begin
          if (!brk) begin
            held_nxt = held_r + fwc_pkg::CNT_W'(1);
            if (held_zero) run_start_nxt = in_data.byte_address;
          end
        end
        fwc_pkg::OP_CLEAR: held_nxt = '0;
        default: ;
      endcase
    end else if (cmd.finish) begin
      if (pend_write_r) begin
        held_nxt      = fwc_pkg::CNT_W'(1);
        run_start_nxt = pend_addr_r;
      end else begin
        held_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      run_start_r  <= '0;
      pend_write_r <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      run_start_r <= run_start_nxt;
      if (cmd.take) pend_write_r <= is_write && brk;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_addr_r <= in_data.byte_address;
      pend_data_r <= in_data.data_byte;
    end
  end

  // buffer memory: one byte-lane write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.take && is_write && !brk) begin
      mem[wr_widx][{wr_lane, 3'b000} +: 8] <= in_data.data_byte;
    end else if (cmd.finish && pend_write_r) begin
      mem[0][7:0] <= pend_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r  <= mem[cmd.word_idx];
      out_addr_r <= run_start_r + fwc_pkg::ADDR_W'({cmd.word_idx, 2'b00});
    end
  end

  // pad lanes past the held tail with 0xff
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (stat.last && (held_r[1:0] != 2'd0) && (2'(k) >= held_r[1:0])) begin
        word_pad[8*k +: 8] = fwc_pkg::PAD_BYTE;
      end else begin
        word_pad[8*k +: 8] = rd_data_r[8*k +: 8];
      end
    end
  end

  assign out_data.word_address = out_addr_r;
  assign out_data.word_data    = word_pad;
  assign out_data.last_word    = stat.last;

endmodule
`default_nettype wire

[sv/fwc_ctrl.sv]
`default_nettype none
module fwc_ctrl (
  input  wire                     logic clk,
  input  wire                     logic rst_n,
  input  wire                     logic in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire                     logic out_ready,
  input  wire fwc_pkg::fwc_stat_t stat,
  output fwc_pkg::fwc_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t                     state_r, state_nxt;
  logic [fwc_pkg::WIDX_W-1:0] idx_r, idx_nxt;

  assign in_ready     = (state_r == ST_IDLE);
  assign out_valid    = (state_r == ST_EMIT);
  assign cmd.take     = in_valid && in_ready;
  assign cmd.rd_en    = (state_r == ST_READ);
  assign cmd.finish   = out_valid && out_ready && stat.last;
  assign cmd.word_idx = idx_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.take && stat.need_flush) begin
          state_nxt = ST_READ;
          idx_nxt   = '0;
        end
      end
      ST_READ: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_ready) begin
          if (stat.last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_READ;
            idx_nxt   = idx_r + fwc_pkg::WIDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_no_take_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken during a word burst");

  a_burst_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && stat.need_flush) |=> (state_r == ST_READ) && (idx_r == '0))
    else $error("burst did not start at word 0");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(idx_r))
    else $error("word index moved under stall");

  a_step_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !stat.last) |=> (state_r == ST_READ) &&
      (idx_r == $past(idx_r) + fwc_pkg::WIDX_W'(1)))
    else $error("word index did not advance after transfer");

endmodule
`default_nettype wire

[sv/flash_write_combiner.sv]
`default_nettype none
// Write-combining buffer for flash programming. Byte writes (op write) are
// gathered into a 128-byte run held in an internal RAM; each result transfer
// is one 4-byte program word, lowest address in the low byte, with
// last_word set on the final word caused by an input item. A write that does
// not continue the run, a flush op on a nonempty run, or the write that fills
// the buffer starts a burst of up to 32 words; a partial tail word is padded
// with 0xff (except after a fill, which has none). A clear op drops the run;
// op code 3 and flush/clear on an empty run give nothing. Throughput: items
// that emit nothing are taken back to back, so bytes stream at one per clock
// while no burst runs. During a burst the buffer RAM, which has one read port,
// reads each word into the output register in the read state, and the word is
// held there in the emit state until its transfer, however long the output
// stalls. in_ready stays low for the whole burst. The buffer needs no clearing pass after reset.
module flash_write_combiner (
  input  wire                   logic clk,
  input  wire                   logic rst_n,
  input  wire                   logic in_valid,
  output logic                  in_ready,
  input  wire fwc_pkg::fwc_in_t in_data,
  output logic                  out_valid,
  input  wire                   logic out_ready,
  output fwc_pkg::fwc_out_t     out_data
);

  fwc_pkg::fwc_cmd_t  cmd;
  fwc_pkg::fwc_stat_t stat;

  // sequencing: idle / read word / present word
  fwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // run buffer, held count, run start, output word forming
  fwc_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
